/* design/mdws_pkg.sv */
// Shared types and constants for the mouse delta weighted smoother.
// No dependencies; used by every module of the block.
package mdws_pkg;

   localparam int DELTA_W  = 16;        // raw motion count
   localparam int WAVG_W   = 24;        // Q.8 weighted mean and result
   localparam int FRAC_W   = 8;
   localparam int COEF_W   = 17;        // Q.16 weight, up to 1.0
   localparam int WEIGHT_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_FACTOR = 2'd1;

   localparam logic [COEF_W-1:0]   COEF_ONE       = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET   = 16'd32768;

   typedef struct packed {
      logic push;     // shift toward older, new sample enters cell 0
      logic rotate;   // shift toward cell 0, cell 0 wraps to the end
   } hist_ctrl_type;

endpackage

/* design/mdws_hist_cell.sv */
// One history tap of the smoother: holds one x and one y sample.
// Depends on mdws_pkg.
module mdws_hist_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mdws_pkg::hist_ctrl_type              ctrl,
   input  logic signed [mdws_pkg::DELTA_W-1:0]  prev_x,
   input  logic signed [mdws_pkg::DELTA_W-1:0]  prev_y,
   input  logic signed [mdws_pkg::DELTA_W-1:0]  next_x,
   input  logic signed [mdws_pkg::DELTA_W-1:0]  next_y,
   output logic signed [mdws_pkg::DELTA_W-1:0]  tap_x,
   output logic signed [mdws_pkg::DELTA_W-1:0]  tap_y
);

   logic signed [mdws_pkg::DELTA_W-1:0] x_ff, x_in, y_ff, y_in;

   always_comb begin
      priority if (ctrl.push) begin
         x_in = prev_x;
         y_in = prev_y;
      end else if (ctrl.rotate) begin
         x_in = next_x;
         y_in = next_y;
      end else begin
         x_in = x_ff;
         y_in = y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign tap_x = x_ff;
   assign tap_y = y_ff;

endmodule

/* design/mdws_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Quotient must fit WAVG_W bits. Depends on mdws_pkg.
module mdws_divider #(
   parameter int NW = 46,
   parameter int DW = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [NW-1:0]                     dividend,
   input  logic [DW-1:0]                     divisor,
   output logic                              done,
   output logic [mdws_pkg::WAVG_W-1:0]       quotient
);

   localparam int QW    = mdws_pkg::WAVG_W;
   localparam int CNT_W = $clog2(QW);

   logic [DW-1:0]    rem_ff, div_ff;
   logic [QW-1:0]    quo_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DW:0]      shifted, diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[QW-1]};
      diff    = shifted - {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= dividend[QW+DW-1:QW];
            quo_ff  <= dividend[QW-1:0];
            div_ff  <= divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!diff[DW]) begin
               rem_ff <= diff[DW-1:0];
               quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[DW-1:0];
               quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* design/mouse_delta_weighted_smoother.sv */
// Top level of the mouse delta weighted smoother: history cell chain, MAC, dividers.
// Depends on mdws_pkg, mdws_hist_cell, mdws_divider.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     req_tdata  {delta_y, delta_x}
//   rsp_     out  rsp_tvalid/tready     rsp_tdata  {smooth_y, smooth_x}
//   csr_     in   csr_we                csr_index, csr_wdata
//
// Filtered item: push into cell 0, MAC over the history as it rotates past cell 0,
// then setup, the divider run, finish and the move to the output register.
// Pass-through item: finish, then the output register. One item in work at a time;
// req_tready is high while idle, also when a result still waits in the output register.
// Synchronous reset clears history and prior means, and returns the state and CSRs to defaults.
module mouse_delta_weighted_smoother #(
   parameter int HISTORY_DEPTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // delta_x, delta_y
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [47:0]                         rsp_tdata,  // smooth_x, smooth_y
   input  logic                                csr_we,
   input  logic [mdws_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mdws_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int DW_IN  = mdws_pkg::DELTA_W;
   localparam int QW     = mdws_pkg::WAVG_W;
   localparam int CW     = mdws_pkg::COEF_W;
   localparam int WW     = mdws_pkg::WEIGHT_W;
   localparam int DEN_W  = CW + $clog2(HISTORY_DEPTH);
   localparam int NUM_W  = DEN_W + DW_IN;
   localparam int NW     = NUM_W + 9;
   localparam int DIV_W  = DEN_W + 1;
   localparam int CNT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   typedef enum logic [2:0] {IDLE, MAC, PREP, DIV, DONE} state_type;

   state_type state_ff;
   logic      filter_en_ff;
   logic [WW-1:0] weight_ff;

   logic [CNT_W-1:0]         cnt_ff;
   logic [CW-1:0]            coef_ff;
   logic [DEN_W-1:0]         den_ff;
   logic signed [NUM_W-1:0]  num_x_ff, num_y_ff;
   logic                     neg_x_ff, neg_y_ff;
   logic signed [QW-1:0]     prior_x_ff, prior_y_ff;
   logic signed [QW-1:0]     res_x_ff, res_y_ff;
   logic                     rsp_valid_ff;
   logic [2*QW-1:0]          rsp_data_ff;

   logic                     accept;
   logic signed [DW_IN-1:0]  in_x, in_y;
   mdws_pkg::hist_ctrl_type  hctrl;
   logic signed [DW_IN-1:0]  hx [HISTORY_DEPTH];
   logic signed [DW_IN-1:0]  hy [HISTORY_DEPTH];

   logic [CW+WW-1:0]         coef_prod;
   logic [CW-1:0]            coef_in;
   logic signed [DW_IN+CW:0] prod_x, prod_y;
   logic [NUM_W-1:0]         mag_x, mag_y;
   logic [NW-1:0]            dvd_x, dvd_y;
   logic                     div_start, done_x, done_y;
   logic [QW-1:0]            quo_x, quo_y;
   logic signed [QW-1:0]     wavg_x, wavg_y;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == IDLE);
   assign in_x       = req_tdata[DW_IN-1:0];
   assign in_y       = req_tdata[2*DW_IN-1:DW_IN];

   assign hctrl.push   = accept && filter_en_ff;
   assign hctrl.rotate = (state_ff == MAC);

   genvar g;
   generate
      for (g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
         logic signed [DW_IN-1:0] px, py, nx, ny;
         if (g == 0) begin : g_first
            assign px = in_x;
            assign py = in_y;
         end else begin : g_mid
            assign px = hx[g-1];
            assign py = hy[g-1];
         end
         if (g == HISTORY_DEPTH - 1) begin : g_last
            assign nx = hx[0];
            assign ny = hy[0];
         end else begin : g_inner
            assign nx = hx[g+1];
            assign ny = hy[g+1];
         end
         mdws_hist_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (hctrl),
            .prev_x (px),
            .prev_y (py),
            .next_x (nx),
            .next_y (ny),
            .tap_x  (hx[g]),
            .tap_y  (hy[g])
         );
      end
   endgenerate

   function automatic logic signed [QW-1:0] half_round(input logic signed [QW-1:0] a,
                                                       input logic signed [QW-1:0] b);
      logic signed [QW:0] s;
      logic [QW:0]        m;
      s = {a[QW-1], a} + {b[QW-1], b};
      m = s[QW] ? (QW+1)'(-s) : (QW+1)'(s);
      m = (m + 1'b1) >> 1;
      half_round = s[QW] ? QW'(-m) : QW'(m);
   endfunction

   always_comb begin
      coef_prod = coef_ff * weight_ff;
      coef_in   = coef_prod[CW+WW-1:WW] + {{(CW-1){1'b0}}, coef_prod[WW-1]};
      prod_x    = hx[0] * $signed({1'b0, coef_ff});
      prod_y    = hy[0] * $signed({1'b0, coef_ff});
      mag_x     = num_x_ff[NUM_W-1] ? NUM_W'(-num_x_ff) : NUM_W'(num_x_ff);
      mag_y     = num_y_ff[NUM_W-1] ? NUM_W'(-num_y_ff) : NUM_W'(num_y_ff);
      dvd_x     = {mag_x, 9'b0} + NW'(den_ff);
      dvd_y     = {mag_y, 9'b0} + NW'(den_ff);
      div_start = (state_ff == PREP);
      wavg_x    = neg_x_ff ? QW'(-quo_x) : QW'(quo_x);
      wavg_y    = neg_y_ff ? QW'(-quo_y) : QW'(quo_y);
   end

   mdws_divider #(.NW(NW), .DW(DIV_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_x),
      .divisor  ({den_ff, 1'b0}),
      .done     (done_x),
      .quotient (quo_x)
   );

   mdws_divider #(.NW(NW), .DW(DIV_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_y),
      .divisor  ({den_ff, 1'b0}),
      .done     (done_y),
      .quotient (quo_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         filter_en_ff <= 1'b1;
         weight_ff    <= mdws_pkg::WEIGHT_RESET;
         prior_x_ff   <= '0;
         prior_y_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               mdws_pkg::CSR_FILTER_ENABLE: filter_en_ff <= csr_wdata[0];
               mdws_pkg::CSR_WEIGHT_FACTOR: weight_ff    <= csr_wdata[WW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  if (filter_en_ff) begin
                     num_x_ff <= '0;
                     num_y_ff <= '0;
                     den_ff   <= '0;
                     coef_ff  <= mdws_pkg::COEF_ONE;
                     cnt_ff   <= '0;
                     state_ff <= MAC;
                  end else begin
                     res_x_ff <= {in_x, {mdws_pkg::FRAC_W{1'b0}}};
                     res_y_ff <= {in_y, {mdws_pkg::FRAC_W{1'b0}}};
                     state_ff <= DONE;
                  end
               end
            end
            MAC: begin
               num_x_ff <= num_x_ff + NUM_W'(prod_x);
               num_y_ff <= num_y_ff + NUM_W'(prod_y);
               den_ff   <= den_ff + DEN_W'(coef_ff);
               coef_ff  <= coef_in;
               cnt_ff   <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(HISTORY_DEPTH - 1)) begin
                  state_ff <= PREP;
               end
            end
            PREP: begin
               neg_x_ff <= num_x_ff[NUM_W-1];
               neg_y_ff <= num_y_ff[NUM_W-1];
               state_ff <= DIV;
            end
            DIV: begin
               if (done_x && done_y) begin
                  res_x_ff   <= half_round(wavg_x, prior_x_ff);
                  res_y_ff   <= half_round(wavg_y, prior_y_ff);
                  prior_x_ff <= wavg_x;
                  prior_y_ff <= wavg_y;
                  state_ff   <= DONE;
               end
            end
            DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {res_y_ff, res_x_ff};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for mouse_delta_weighted_smoother: a directed table, then random
// phases under both filter settings, each result checked against its typed value or an in-bench predictor.
// Depends on mdws_pkg and the design sources; reads nothing, needs no arguments.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST            = 10;
   localparam int RANDOM_ITEMS    = 930;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int TAIL_CYCLES     = 64;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int PLAN_ROWS       = 26;

   localparam logic [mdws_pkg::CSR_IDX_W-1:0] CSR_FILTER_ENABLE = mdws_pkg::CSR_FILTER_ENABLE;
   localparam logic [mdws_pkg::CSR_IDX_W-1:0] CSR_WEIGHT_FACTOR = mdws_pkg::CSR_WEIGHT_FACTOR;
   localparam logic [mdws_pkg::CSR_IDX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [mdws_pkg::CSR_IDX_W-1:0] CSR_UNUSED_3 = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;
   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   typedef struct packed {
      logic [mdws_pkg::WAVG_W-1:0] x;
      logic [mdws_pkg::WAVG_W-1:0] y;
   } smooth_pair_type;

   typedef struct packed {
      row_kind_type                      kind;
      logic [mdws_pkg::CSR_IDX_W-1:0]    idx;
      logic [mdws_pkg::DELTA_W-1:0]      a;      // delta_x, or write data
      logic [mdws_pkg::DELTA_W-1:0]      b;      // delta_y
      logic                              typed;
      smooth_pair_type                   want;
   } row_type;

   localparam smooth_pair_type NO_PAIR = '{24'h0, 24'h0};

   // typed rows: state right after reset, and raw pass-through of the extremes
   row_type plan [PLAN_ROWS] = '{
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h0000, 16'h0000, 1'b1, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h7FFF, 16'h8000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h8000, 16'h7FFF, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h0001, 16'hFFFF, 1'b0, NO_PAIR},
      '{ROW_CSR,  CSR_WEIGHT_FACTOR, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h7FFF, 16'h7FFF, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h8000, 16'h8000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h0000, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_CSR,  CSR_WEIGHT_FACTOR, 16'hFFFF, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h7FFF, 16'h7FFF, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h7FFF, 16'h7FFF, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h8000, 16'h8000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h3039, 16'hCFC7, 1'b0, NO_PAIR},
      '{ROW_CSR,  CSR_FILTER_ENABLE, 16'hFFFE, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h7FFF, 16'h8000, 1'b1, '{24'h7FFF00, 24'h800000}},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h8000, 16'h7FFF, 1'b1, '{24'h800000, 24'h7FFF00}},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h0000, 16'h0000, 1'b1, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'hFFFF, 16'h0001, 1'b1, '{24'hFFFF00, 24'h000100}},
      '{ROW_CSR,  CSR_UNUSED_2,      16'hFFFF, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_CSR,  CSR_UNUSED_3,      16'h0000, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_CSR,  CSR_FILTER_ENABLE, 16'h0001, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h0005, 16'hFFFB, 1'b0, NO_PAIR},
      '{ROW_CSR,  CSR_WEIGHT_FACTOR, 16'h0001, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'h0064, 16'hFF9C, 1'b0, NO_PAIR},
      '{ROW_CSR,  CSR_WEIGHT_FACTOR, 16'h8000, 16'h0000, 1'b0, NO_PAIR},
      '{ROW_ITEM, CSR_FILTER_ENABLE, 16'hFFFF, 16'hFFFF, 1'b0, NO_PAIR}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [31:0]                     req_tdata = '0;     // delta_x [15:0], delta_y [31:16]
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [47:0]                     rsp_tdata;          // smooth_x [23:0], smooth_y [47:24]
   logic                            csr_we = 1'b0;
   logic [mdws_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [mdws_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic                                 filt_on;
   logic [mdws_pkg::WEIGHT_W-1:0]        decay;
   logic signed [mdws_pkg::DELTA_W-1:0]  hist [2][HIST];
   logic signed [mdws_pkg::WAVG_W-1:0]   prior_mean [2];

   smooth_pair_type expected_q [$];
   int              fail_count = 0;
   int              quiet_cycles = 0;
   int              burst_left = 0;
   int              hold_req = 0;
   int              hold_seen = 0;
   int              hold_left = 0;
   int              mode_left = 0;
   rx_mode_type     rx_mode = RX_ALWAYS;
   logic [3:0]      rx_cycle = '0;

   mouse_delta_weighted_smoother #(.HISTORY_DEPTH(HIST)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint round_half_away(input longint n, input longint d);
      if (n >= 0) return (2 * n + d) / (2 * d);
      return -((-2 * n + d) / (2 * d));
   endfunction

   function automatic smooth_pair_type predict_smooth(input logic [15:0] dx,
                                                      input logic [15:0] dy);
      logic signed [mdws_pkg::DELTA_W-1:0] d [2];
      logic [mdws_pkg::WAVG_W-1:0]         r [2];
      longint                              num, den, mean;
      longint unsigned                     c;
      smooth_pair_type                     p;
      d[0] = dx;
      d[1] = dy;
      for (int a = 0; a < 2; a++) begin
         if (!filt_on) begin
            r[a] = mdws_pkg::WAVG_W'(longint'(d[a]) * 256);
         end else begin
            for (int i = HIST - 1; i > 0; i--) hist[a][i] = hist[a][i-1];
            hist[a][0] = d[a];
            num = 0;
            den = 0;
            c = 65536;
            for (int i = 0; i < HIST; i++) begin
               num += longint'(hist[a][i]) * longint'(c);
               den += longint'(c);
               c = (c * decay + 32768) >> 16;
            end
            mean = round_half_away(num * 256, den);
            r[a] = mdws_pkg::WAVG_W'(round_half_away(mean + longint'(prior_mean[a]), 2));
            prior_mean[a] = mdws_pkg::WAVG_W'(mean);
         end
      end
      p.x = r[0];
      p.y = r[1];
      return p;
   endfunction

   function automatic logic [15:0] pick_delta(input logic [15:0] prev);
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2, 3:    return 16'($urandom_range(0, 128) - 64);
         4:       return prev;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void note_failure(input string what, input logic [23:0] want,
                                        input logic [23:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch %s: expected %06h, got %06h at %0t", what, want, got, $realtime);
   endfunction

   task automatic send_item(input logic [15:0] dx, input logic [15:0] dy, input logic typed,
                            input smooth_pair_type typed_val);
      smooth_pair_type want;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {dy, dx};
      do @(posedge clock); while (!req_tready);
      want = predict_smooth(dx, dy);
      if (typed) want = typed_val;
      expected_q.push_back(want);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   task automatic write_csr(input logic [mdws_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mdws_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_FILTER_ENABLE) filt_on = val[0];
      else if (idx == CSR_WEIGHT_FACTOR) decay = val[mdws_pkg::WEIGHT_W-1:0];
   endtask

   // result side: receiver stall pattern plus the long hold-off on request
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1'b1;
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(32, 256);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            RX_ALWAYS: rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:   rsp_tready <= rx_cycle[2];
         endcase
      end
   end

   always @(posedge clock) begin : check_rsp
      smooth_pair_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            note_failure("unexpected item", 24'h0, rsp_tdata[23:0]);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata[23:0] !== want.x) note_failure("smooth_x", want.x, rsp_tdata[23:0]);
            if (rsp_tdata[47:24] !== want.y) note_failure("smooth_y", want.y, rsp_tdata[47:24]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int            sent;
      int            phase;
      int            n;
      logic [15:0]   w;
      logic [15:0]   last_dx;
      logic [15:0]   last_dy;
      filt_on = 1'b1;
      decay = mdws_pkg::WEIGHT_RESET;
      for (int a = 0; a < 2; a++) begin
         prior_mean[a] = '0;
         for (int i = 0; i < HIST; i++) hist[a][i] = '0;
      end
      sent = 0;
      phase = 0;
      last_dx = '0;
      last_dy = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (plan[r].kind == ROW_CSR) begin
            wait_drained();
            write_csr(plan[r].idx, plan[r].a);
         end else begin
            send_item(plan[r].a, plan[r].b, plan[r].typed, plan[r].want);
         end
      end

      while (sent < RANDOM_ITEMS) begin
         wait_drained();
         case ($urandom_range(0, 5))
            0:       w = 16'h0000;
            1:       w = 16'hFFFF;
            2:       w = 16'h8000;
            3:       w = 16'h0001;
            default: w = 16'($urandom);
         endcase
         write_csr(CSR_WEIGHT_FACTOR, w);
         if ($urandom_range(0, 3) == 0)
            write_csr($urandom_range(0, 1) ? CSR_UNUSED_2 : CSR_UNUSED_3, 16'($urandom));
         write_csr(CSR_FILTER_ENABLE,
                   {15'($urandom), 1'(phase < 3 || $urandom_range(0, 3) != 0)});
         n = $urandom_range(16, 80);
         for (int k = 0; k < n; k++) begin
            if (phase == 1 && k == 4) hold_req <= hold_req + 1;
            if (phase == 2 && k == n / 2) wait_drained();
            last_dx = pick_delta(last_dx);
            last_dy = pick_delta(last_dy);
            send_item(last_dx, last_dy, 1'b0, NO_PAIR);
            sent++;
         end
         phase++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
